>>> hdl/utbwd_pkg.sv
// Shared types and constants for the serial byte/word/decimal transmitter.
package utbwd_pkg;

  localparam logic [1:0] KIND_RAW  = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [15:0] PERIOD_RESET = 16'd104;

  // Frame: start bit, eight data bits, two stop bits
  localparam logic [3:0] LAST_BIT_IDX = 4'd10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;   // final frame of its request
  } tx_ent_t;

endpackage

>>> hdl/utbwd_if.sv
// Channel interfaces: send request in, one beat per bit period out.
interface utbwd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface utbwd_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic frame_end;
  logic last;
  modport source (output valid, line_level, frame_end, last, input ready);
  modport sink   (input valid, line_level, frame_end, last, output ready);
endinterface

>>> hdl/utbwd_front.sv
// Front end: accept requests and break them into bytes to be framed.
module utbwd_front (
  input  logic               clk,
  input  logic               rst_n,
  utbwd_in_if.sink           in_ch,
  output logic               push,
  output utbwd_pkg::tx_ent_t push_ent,
  input  logic               full
);
  import utbwd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  byte_r [3];
  logic [7:0]  byte_nxt [3];
  logic [1:0]  lastidx_r, lastidx_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] q_r, q_nxt;

  logic [32:0] prod;
  logic [15:0] quo;
  logic [15:0] rem;
  logic [1:0]  dig_pos;
  logic        push_last;
  logic        accept;

  // one divide-by-ten step a cycle: units first, hundreds last
  assign prod    = {17'd0, q_r} * {16'd0, DIV10_MUL};
  assign quo     = {2'd0, prod[32:DIV10_SHIFT]};
  assign rem     = q_r - (quo << 3) - (quo << 1);
  assign dig_pos = 2'd2 - cnt_r;

  assign push          = (state_r == S_PUSH);
  assign push_ent.data = byte_r[idx_r];
  assign push_ent.last = (idx_r == lastidx_r);
  assign push_last     = push && !full && (idx_r == lastidx_r);

  assign in_ch.ready = (state_r == S_IDLE) || push_last;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    byte_nxt    = byte_r;
    lastidx_nxt = lastidx_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    q_nxt       = q_r;
    if (accept) begin
      idx_nxt = 2'd0;
      cnt_nxt = 2'd0;
      unique case (in_ch.kind)
        KIND_RAW: begin
          byte_nxt[0] = in_ch.value[7:0];
          lastidx_nxt = 2'd0;
          state_nxt   = S_PUSH;
        end
        KIND_WORD: begin
          byte_nxt[0] = in_ch.value[15:8];
          byte_nxt[1] = in_ch.value[7:0];
          lastidx_nxt = 2'd1;
          state_nxt   = S_PUSH;
        end
        KIND_DEC: begin
          q_nxt       = in_ch.value;
          lastidx_nxt = 2'd2;
          state_nxt   = S_DIV;
        end
        default: begin
          // unused kind: drop the request
          state_nxt = S_IDLE;
        end
      endcase
    end else begin
      unique case (state_r)
        S_DIV: begin
          byte_nxt[dig_pos] = ASCII_ZERO + {4'd0, rem[3:0]};
          q_nxt             = quo;
          cnt_nxt           = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            state_nxt = S_PUSH;
          end
        end
        S_PUSH: begin
          if (!full) begin
            if (idx_r == lastidx_r) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    lastidx_r <= lastidx_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    q_r       <= q_nxt;
  end

endmodule

>>> hdl/utbwd_fifo.sv
// Short byte queue between the front end and the line sequencer.
module utbwd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  utbwd_pkg::tx_ent_t push_ent,
  output logic               full,
  input  logic               pop,
  output utbwd_pkg::tx_ent_t pop_ent,
  output logic               empty
);
  import utbwd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  tx_ent_t       mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_ent = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_MAX) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_MAX) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

endmodule

>>> hdl/utbwd_back.sv
// Back end: frame each queued byte and pace one output beat per bit period.
module utbwd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        period,
  input  utbwd_pkg::tx_ent_t pop_ent,
  input  logic               empty,
  output logic               pop,
  utbwd_out_if.source        out_ch
);
  import utbwd_pkg::*;

  logic        act_r, act_nxt;
  logic [9:0]  frame_r, frame_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic        lastf_r, lastf_nxt;
  logic [15:0] tmr_r, tmr_nxt;
  logic        ov_r, ov_nxt;
  logic        lvl_r, lvl_nxt;
  logic        fend_r, fend_nxt;
  logic        last_r, last_nxt;

  logic can_emit, ld, at_end;

  assign can_emit = (!ov_r || out_ch.ready) && (tmr_r == '0);
  assign ld       = can_emit && (act_r || !empty);
  assign pop      = ld && !act_r;
  assign at_end   = (bit_r == LAST_BIT_IDX);

  assign out_ch.valid      = ov_r;
  assign out_ch.line_level = lvl_r;
  assign out_ch.frame_end  = fend_r;
  assign out_ch.last       = last_r;

  always_comb begin
    act_nxt   = act_r;
    frame_nxt = frame_r;
    bit_nxt   = bit_r;
    lastf_nxt = lastf_r;
    tmr_nxt   = tmr_r;
    ov_nxt    = ov_r;
    lvl_nxt   = lvl_r;
    fend_nxt  = fend_r;
    last_nxt  = last_r;
    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (tmr_r != '0) begin
      tmr_nxt = tmr_r - 16'd1;
    end
    if (ld) begin
      ov_nxt  = 1'b1;
      tmr_nxt = (period == '0) ? '0 : period - 16'd1;
      if (!act_r) begin
        // start bit; stop bits ride in above the data
        act_nxt   = 1'b1;
        frame_nxt = {2'b11, pop_ent.data};
        bit_nxt   = 4'd1;
        lastf_nxt = pop_ent.last;
        lvl_nxt   = 1'b0;
        fend_nxt  = 1'b0;
        last_nxt  = 1'b0;
      end else begin
        lvl_nxt   = frame_r[0];
        frame_nxt = {1'b1, frame_r[9:1]};
        fend_nxt  = at_end;
        last_nxt  = at_end && lastf_r;
        bit_nxt   = bit_r + 4'd1;
        if (at_end) begin
          act_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      tmr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      tmr_r <= tmr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    bit_r   <= bit_nxt;
    lastf_r <= lastf_nxt;
    lvl_r   <= lvl_nxt;
    fend_r  <= fend_nxt;
    last_r  <= last_nxt;
  end

endmodule

>>> hdl/uart_tx_byte_word_decimal.sv
// Serial transmitter, 8 data bits, no parity, two stop bits, with decimal-to-ASCII requests.
//
// A request on in_ch is a raw byte (kind 0, low eight bits of value), a word
// (kind 1, high byte then low byte) or a decimal (kind 2, hundreds, tens and
// units digits of value as ASCII characters); kind 3 is accepted and dropped.
// Each byte goes out as an eleven-bit frame: start bit 0, data LSB first, two
// stop bits 1. Every bit period is one beat on out_ch carrying line_level,
// frame_end (second stop bit) and last (final beat of the request). Beats are
// paced by the bit timer in the back end, which is loaded from bit_period_cycles
// when a beat is loaded (a value of 0 acts as 1); the next beat waits for it and
// for out_ch to take the held beat, so a request is 11, 22 or 33 beats and that
// timer sets the sustained rate. The front end takes a new request as soon as
// the previous one has pushed its bytes, one at a time while the queue is not full,
// into the FIFO_DEPTH-entry queue, after three divide-by-ten steps for a decimal request.
// Write bit_period_cycles through cfg_we/cfg_wdata only while the block is idle.
module uart_tx_byte_word_decimal #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  utbwd_in_if.sink    in_ch,
  utbwd_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import utbwd_pkg::*;

  logic [15:0] period_r, period_nxt;
  tx_ent_t     push_ent, pop_ent;
  logic        push, full, pop, empty;

  // hold the bit period register; take a new value on each write
  assign period_nxt = cfg_we ? cfg_wdata : period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else begin
      period_r <= period_nxt;
    end
  end

  // front: accept and split requests into bytes
  utbwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_ent (push_ent),
    .full     (full)
  );

  // queue: lets the front take the next request while a frame is on the line
  utbwd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .pop_ent  (pop_ent),
    .empty    (empty)
  );

  // back: frame bytes and advance one beat per bit period
  utbwd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .period  (period_r),
    .pop_ent (pop_ent),
    .empty   (empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> hdl/utbwd_chk.sv
// Port-level checks for the transmitter, bound to the top level.
module utbwd_chk (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_level,
  input logic out_frame_end,
  input logic out_last
);

  // a stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_level)
      && $stable(out_frame_end) && $stable(out_last))
    else $error("stalled beat changed");

  // a request ends only on the end of a frame
  a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_frame_end)
    else $error("last without frame_end");

  // the second stop bit is always high
  a_stop_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_line_level)
    else $error("stop bit low");

  // no beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("beat offered after reset");

endmodule

bind uart_tx_byte_word_decimal utbwd_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_line_level (out_ch.line_level),
  .out_frame_end  (out_ch.frame_end),
  .out_last       (out_ch.last)
);

>>> sim/utbwd_line_checker.sv
// Checker for the serial transmitter: predicts the line beats of each request and compares them.
module utbwd_line_checker (
  input  logic clk,
  input  logic rst_n,
  utbwd_in_if  in_ch,
  utbwd_out_if out_ch,
  output int   mismatches,
  output int   beats_due,
  output int   beats_seen
);
  import utbwd_pkg::*;

  localparam int FRAME_LEN = 11;

  typedef struct packed {
    logic line_level;
    logic frame_end;
    logic last;
  } line_beat_t;

  line_beat_t line_due[$];
  int         err_count  = 0;
  int         beat_count = 0;

  // Start bit 0, data LSB first, two stop bits of 1.
  function automatic void push_frame(input logic [7:0] data, input logic final_frame);
    line_beat_t b;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == 0) begin
        b.line_level = 1'b0;
      end else if (i <= 8) begin
        b.line_level = data[i-1];
      end else begin
        b.line_level = 1'b1;
      end
      b.frame_end = (i == FRAME_LEN - 1);
      b.last      = b.frame_end && final_frame;
      line_due.push_back(b);
    end
  endfunction

  function automatic void push_request(input logic [1:0] kind, input logic [15:0] value);
    int unsigned v;
    v = value;
    case (kind)
      KIND_RAW: push_frame(value[7:0], 1'b1);
      KIND_WORD: begin
        push_frame(value[15:8], 1'b0);
        push_frame(value[7:0], 1'b1);
      end
      KIND_DEC: begin
        // thousands and ten-thousands fall away
        push_frame(ASCII_ZERO + 8'((v / 100) % 10), 1'b0);
        push_frame(ASCII_ZERO + 8'((v / 10) % 10), 1'b0);
        push_frame(ASCII_ZERO + 8'(v % 10), 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %s", msg);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    line_beat_t want;
    if (rst_n) begin
      // compare the outgoing beat before queueing what this edge accepts
      if (out_ch.valid && out_ch.ready) begin
        if (line_due.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing due", beat_count));
        end else begin
          want = line_due.pop_front();
          if (out_ch.line_level !== want.line_level)
            report_mismatch($sformatf("beat %0d line_level %0b, expected %0b",
                                      beat_count, out_ch.line_level, want.line_level));
          if (out_ch.frame_end !== want.frame_end)
            report_mismatch($sformatf("beat %0d frame_end %0b, expected %0b",
                                      beat_count, out_ch.frame_end, want.frame_end));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("beat %0d last %0b, expected %0b",
                                      beat_count, out_ch.last, want.last));
        end
        beat_count++;
      end
      if (in_ch.valid && in_ch.ready) push_request(in_ch.kind, in_ch.value);
    end
    mismatches <= err_count;
    beats_due  <= line_due.size();
    beats_seen <= beat_count;
  end

endmodule

>>> sim/tb_uart_tx_byte_word_decimal.sv
// Testbench top for the serial transmitter: stimulus, bit period phases and the verdict.
module tb_uart_tx_byte_word_decimal;
  import utbwd_pkg::*;

  // Kind that the block takes and drops without a line beat
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Quiet cycles tolerated: a bit period of 65535 plus the longest stall, several times over
  localparam int QUIET_LIMIT = 300000;
  // Long receiver hold-off that fills the byte queue and stalls the input
  localparam int HOLD_CYCLES = 300;
  // Front end settle time once the line has gone quiet
  localparam int SETTLE      = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int          mismatches;
  int          beats_due;
  int          beats_seen;

  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned period_now  = PERIOD_RESET;
  int          kind_sent[4] = '{0, 0, 0, 0};

  utbwd_in_if  in_ch();
  utbwd_out_if out_ch();

  uart_tx_byte_word_decimal i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  utbwd_line_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .beats_due  (beats_due),
    .beats_seen (beats_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold every block input at a known level from time zero.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_RAW;
    in_ch.value = '0;
  end

  // Receiver: ready changes on the falling edge and drops low in random bursts of
  // stall; a hold request from the stimulus turns into one long stall that is
  // counted down here, while the sender carries on offering requests.
  initial begin : sink
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Return on the
  // falling edge after the handshake with valid still high, so a following
  // request keeps valid up without a glitch.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] value);
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    kind_sent[kind]++;
  endtask

  // Drop valid, wait for the line to drain and for the last bit period and
  // the front end to settle, then write the bit period.
  task automatic set_bit_period(input logic [15:0] cycles);
    in_ch.valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (((period_now == 0) ? 1 : period_now) + SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cycles;
    @(negedge clk);
    cfg_we    <= 1'b0;
    period_now = cycles;
  endtask

  // Random requests, mostly well formed, with the odd unused kind as noise.
  // Only requests that put beats on the line count towards the total; a hold
  // can be asked for halfway through.
  task automatic random_requests(input int unsigned n_real, input bit with_hold);
    int unsigned n_done;
    logic [1:0]  kind;
    logic [15:0] value;
    n_done = 0;
    while (n_done < n_real) begin
      kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0:       value = 16'h0000;
        1:       value = 16'hFFFF;
        2:       value = 16'($urandom_range(0, 999));
        default: value = 16'($urandom_range(0, 65535));
      endcase
      if (with_hold && n_done == n_real / 2) hold_req = 1'b1;
      send_request(kind, value);
      if (kind != KIND_NONE) n_done++;
    end
  endtask

  initial begin : stimulus
    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset bit period: field extremes, every kind,
    // a raw byte with the high byte set, decimal values whose thousands must
    // drop, and the unused kind.
    send_request(KIND_RAW,  16'h0000);
    send_request(KIND_RAW,  16'h00FF);
    send_request(KIND_RAW,  16'h0055);
    send_request(KIND_RAW,  16'hFFAA);
    send_request(KIND_RAW,  16'hFF00);
    send_request(KIND_WORD, 16'h0000);
    send_request(KIND_WORD, 16'hFFFF);
    send_request(KIND_WORD, 16'hA55A);
    send_request(KIND_WORD, 16'h00FF);
    send_request(KIND_NONE, 16'hFFFF);
    send_request(KIND_DEC,  16'd0);
    send_request(KIND_DEC,  16'd9);
    send_request(KIND_DEC,  16'd99);
    send_request(KIND_DEC,  16'd100);
    send_request(KIND_DEC,  16'd999);
    send_request(KIND_DEC,  16'd1000);
    send_request(KIND_DEC,  16'd12345);
    send_request(KIND_DEC,  16'd65535);
    send_request(KIND_NONE, 16'h0000);
    send_request(KIND_RAW,  16'h0080);

    // A zero bit period is stored as written and must not alter the beats.
    set_bit_period(16'd0);
    random_requests(30, 1'b0);

    // Fastest line.
    set_bit_period(16'd1);
    random_requests(80, 1'b0);

    // A slower line with one long receiver hold-off to back the block up.
    set_bit_period(16'($urandom_range(2, 9)));
    random_requests(70, 1'b1);

    // Slowest line: one frame and one dropped request only.
    set_bit_period(16'hFFFF);
    send_request(KIND_RAW, 16'($urandom_range(0, 65535)));
    send_request(KIND_NONE, 16'($urandom_range(0, 65535)));

    // Last part with no idling on either side.
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    set_bit_period(16'($urandom_range(1, 4)));
    random_requests(40, 1'b0);

    // Drain, then allow a margin for any stray beat.
    in_ch.valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("Sent %0d raw, %0d word, %0d decimal and %0d unused-kind requests;",
             kind_sent[KIND_RAW], kind_sent[KIND_WORD], kind_sent[KIND_DEC],
             kind_sent[KIND_NONE]);
    $display("%0d beats checked at bit periods of 104, 0, 1, a few cycles and 65535,",
             beats_seen);
    $display("with a %0d-cycle hold-off.", HOLD_CYCLES);
    if (mismatches == 0 && beats_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> uart_tx_byte_word_decimal.f
hdl/utbwd_pkg.sv
hdl/utbwd_if.sv
hdl/utbwd_front.sv
hdl/utbwd_fifo.sv
hdl/utbwd_back.sv
hdl/uart_tx_byte_word_decimal.sv
hdl/utbwd_chk.sv
sim/utbwd_line_checker.sv
sim/tb_uart_tx_byte_word_decimal.sv
